>>> hw/rtl/isa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isa_pkg: shared definitions of the integer stack machine
// Widths, opcodes, status codes, cell commands and sequencer states.
// ----------------------------------------------------------------------------
package isa_pkg;

  localparam int DATA_W              = 32;
  localparam int MODE_W              = 4;
  localparam int STATUS_W            = 3;
  localparam int DEPTH_OUT_W         = 7;
  localparam int DEFAULT_STACK_DEPTH = 64;

  localparam logic [MODE_W-1:0] OP_ADD       = 4'd0;
  localparam logic [MODE_W-1:0] OP_SUB       = 4'd1;
  localparam logic [MODE_W-1:0] OP_MUL       = 4'd2;
  localparam logic [MODE_W-1:0] OP_DIV       = 4'd3;
  localparam logic [MODE_W-1:0] OP_PUSH      = 4'd4;
  localparam logic [MODE_W-1:0] OP_LAST_STUB = 4'd10;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 3'd0,
    STATUS_OVERFLOW  = 3'd1,
    STATUS_UNDERFLOW = 3'd2,
    STATUS_UNKNOWN   = 3'd3,
    STATUS_DIVZERO   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_TAKE_UP,
    CELL_TAKE_DOWN
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_PUSH,
    ACT_POP
  } act_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_WB
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

>>> hw/rtl/isa_instr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isa_instr_if: instruction channel
// Valid/ready channel carrying one instruction per transaction.
// ----------------------------------------------------------------------------
interface isa_instr_if;
  import isa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [DATA_W-1:0] immediate;
  logic                     end_of_program;

  modport source (output valid, mode, immediate, end_of_program, input ready);
  modport sink   (input valid, mode, immediate, end_of_program, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/isa_result_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isa_result_if: result channel
// Valid/ready channel carrying one instruction result per transaction.
// ----------------------------------------------------------------------------
interface isa_result_if;
  import isa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] top_value;
  logic [DEPTH_OUT_W-1:0]   depth;
  logic                     program_done;

  modport source (output valid, status, top_value, depth, program_done, input ready);
  modport sink   (input valid, status, top_value, depth, program_done, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/isa_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isa_cell: one stack entry
// Holds one value; takes the neighbour above on a push and the neighbour
// below on a pop.
// ----------------------------------------------------------------------------
module isa_cell (
  input  wire logic                       clk,
  input  wire isa_pkg::cell_cmd_t         cmd,
  input  wire logic [isa_pkg::DATA_W-1:0] from_up,
  input  wire logic [isa_pkg::DATA_W-1:0] from_down,
  output logic      [isa_pkg::DATA_W-1:0] value
);
  import isa_pkg::*;

  always_ff @(posedge clk) begin
    case (cmd)
      CELL_TAKE_UP:   value <= from_up;
      CELL_TAKE_DOWN: value <= from_down;
      default:        value <= value;
    endcase
  end
endmodule
`default_nettype wire

>>> hw/rtl/isa_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isa_divider: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, truncating
// toward zero.
// ----------------------------------------------------------------------------
module isa_divider (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire isa_pkg::div_req_t req,
  output isa_pkg::div_rsp_t      rsp
);
  import isa_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  count;
  logic              negate;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dvs;
  logic [DATA_W:0]   rem_shift;
  logic [DATA_W:0]   diff;

  assign rem_shift = {rem, quo[DATA_W-1]};
  assign diff      = rem_shift - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + CNT_W'(1);
        if (count == CNT_W'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      negate <= req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
      quo    <= req.dividend[DATA_W-1] ? (~req.dividend + DATA_W'(1)) : req.dividend;
      dvs    <= req.divisor[DATA_W-1] ? (~req.divisor + DATA_W'(1)) : req.divisor;
      rem    <= '0;
    end else if (busy) begin
      if (!diff[DATA_W]) begin
        rem <= diff[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= rem_shift[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

  // The negated magnitude of the most negative dividend over minus one wraps
  // back to the most negative value, as two's-complement arithmetic demands.
  assign rsp.done     = done;
  assign rsp.quotient = negate ? (~quo + DATA_W'(1)) : quo;
endmodule
`default_nettype wire

>>> hw/rtl/integer_stack_machine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// integer_stack_machine: 32-bit integer stack machine
// Executes one stack instruction per transaction on a chain of stack cells.
// ----------------------------------------------------------------------------
// Usage. Instructions arrive on the instr channel and every instruction
// produces exactly one transaction on the result channel, in order. The stack
// is a row of STACK_DEPTH cells with the top of stack in cell 0; a push shifts
// every cell one place down and an arithmetic operation writes its result
// into cell 0 while the cells below shift one place up.
// Sequencing: an instruction is accepted, evaluated in the next cycle and
// then written back; write-back waits for a divide to finish and for the
// output register to be free, and no new instruction is taken before the
// current one is written back. A divide runs on a one-bit-per-cycle divider.
// The multiply is registered between evaluation and write-back.
// Reset (synchronous, active high) empties the stack and clears the halt
// state. Any error halts the machine until the next reset; later
// instructions change nothing and report the same error.
// Back-pressure: the result is held in an output register; the next
// instruction may be accepted while it waits, but its write-back stalls until
// the receiver has taken the previous result.
// ----------------------------------------------------------------------------
module integer_stack_machine #(
  parameter int STACK_DEPTH = isa_pkg::DEFAULT_STACK_DEPTH
) (
  input  wire logic    clk,
  input  wire logic    rst,
  isa_instr_if.sink    instr,
  isa_result_if.source result
);
  import isa_pkg::*;

  // Depth counter holds 0 .. STACK_DEPTH inclusive.
  localparam int DW = $clog2(STACK_DEPTH + 1);

  state_t state;
  state_t state_next;

  // Latched instruction.
  logic [MODE_W-1:0] mode_q;
  logic [DATA_W-1:0] imm_q;
  logic              eop_q;

  // Architectural state.
  logic [DW-1:0]   cnt;
  logic            halted;
  status_t         halt_status;

  // Evaluation results carried to write-back.
  act_t              act;
  logic [DATA_W-1:0] alu_result;

  // Output register.
  logic                   out_valid;
  logic [STATUS_W-1:0]    out_status;
  logic [DATA_W-1:0]      out_top;
  logic [DEPTH_OUT_W-1:0] out_depth;
  logic                   out_done;

  // Cell chain.
  logic [DATA_W-1:0] cell_val [STACK_DEPTH];
  cell_cmd_t         cmd_top;
  cell_cmd_t         cmd_rest;
  logic [DATA_W-1:0] top_in;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [DATA_W-1:0] op_a;
  logic [DATA_W-1:0] op_b;

  // Decisions made during evaluation.
  logic    exec_fault;
  status_t exec_code;
  act_t    exec_act;
  logic    exec_div;

  logic accept;
  logic wb_fire;
  logic can_finish;

  logic [DW-1:0]     new_cnt;
  logic [DATA_W-1:0] new_top;

  // The second-from-top entry is the left operand, the top the right one.
  assign op_a = cell_val[1];
  assign op_b = cell_val[0];

  assign accept     = instr.valid && instr.ready;
  assign can_finish = !out_valid || result.ready;

  // ---------------------------------------------------------------------------
  // Evaluation: the error checks come before any change of the stack, and the
  // divide-by-zero check comes after the underflow check.
  // ---------------------------------------------------------------------------
  always_comb begin
    exec_fault = 1'b0;
    exec_code  = STATUS_OK;
    exec_act   = ACT_NONE;
    exec_div   = 1'b0;
    if (!halted) begin
      if (mode_q <= OP_DIV) begin
        if (cnt < DW'(2)) begin
          exec_fault = 1'b1;
          exec_code  = STATUS_UNDERFLOW;
        end else if (mode_q == OP_DIV && op_b == '0) begin
          exec_fault = 1'b1;
          exec_code  = STATUS_DIVZERO;
        end else begin
          exec_act = ACT_POP;
          exec_div = (mode_q == OP_DIV);
        end
      end else if (mode_q == OP_PUSH) begin
        if (cnt == DW'(STACK_DEPTH)) begin
          exec_fault = 1'b1;
          exec_code  = STATUS_OVERFLOW;
        end else begin
          exec_act = ACT_PUSH;
        end
      end else if (mode_q > OP_LAST_STUB) begin
        exec_fault = 1'b1;
        exec_code  = STATUS_UNKNOWN;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = exec_div ? ST_DIV : ST_WB;
      end
      ST_DIV: begin
        if (div_rsp.done) state_next = ST_WB;
      end
      ST_WB: begin
        if (can_finish) state_next = accept ? ST_EXEC : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs. A new instruction is taken while idle, or in the
  // write-back cycle that retires the current one.
  // ---------------------------------------------------------------------------
  always_comb begin
    instr.ready = 1'b0;
    wb_fire     = 1'b0;
    cmd_top     = CELL_HOLD;
    cmd_rest    = CELL_HOLD;
    top_in      = imm_q;
    case (state)
      ST_IDLE: begin
        instr.ready = 1'b1;
      end
      ST_WB: begin
        instr.ready = can_finish;
        wb_fire     = can_finish;
        if (can_finish) begin
          case (act)
            ACT_PUSH: begin
              cmd_top  = CELL_TAKE_UP;
              cmd_rest = CELL_TAKE_UP;
            end
            ACT_POP: begin
              cmd_top  = CELL_TAKE_UP;
              cmd_rest = CELL_TAKE_DOWN;
              top_in   = alu_result;
            end
            default: begin
              cmd_top  = CELL_HOLD;
              cmd_rest = CELL_HOLD;
            end
          endcase
        end
      end
      default: begin
        instr.ready = 1'b0;
      end
    endcase
  end

  assign div_req.start    = (state == ST_EXEC) && exec_div;
  assign div_req.dividend = op_a;
  assign div_req.divisor  = op_b;

  // Stack contents and depth as seen after write-back.
  always_comb begin
    case (act)
      ACT_PUSH: begin
        new_cnt = cnt + DW'(1);
        new_top = imm_q;
      end
      ACT_POP: begin
        new_cnt = cnt - DW'(1);
        new_top = alu_result;
      end
      default: begin
        new_cnt = cnt;
        new_top = (cnt != '0) ? cell_val[0] : '0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cnt         <= '0;
      halted      <= 1'b0;
      halt_status <= STATUS_OK;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_EXEC && exec_fault) begin
        halted      <= 1'b1;
        halt_status <= exec_code;
      end
      if (wb_fire) begin
        cnt       <= new_cnt;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q <= instr.mode;
      imm_q  <= instr.immediate;
      eop_q  <= instr.end_of_program;
    end
    if (state == ST_EXEC) begin
      act <= exec_act;
      case (mode_q)
        OP_ADD:  alu_result <= op_a + op_b;
        OP_SUB:  alu_result <= op_a - op_b;
        OP_MUL:  alu_result <= op_a * op_b;
        default: alu_result <= alu_result;
      endcase
    end
    if (state == ST_DIV && div_rsp.done) begin
      alu_result <= div_rsp.quotient;
    end
    if (wb_fire) begin
      out_status <= halted ? halt_status : STATUS_OK;
      out_top    <= (new_cnt != '0) ? new_top : '0;
      out_depth  <= DEPTH_OUT_W'(new_cnt);
      out_done   <= eop_q;
    end
  end

  assign result.valid        = out_valid;
  assign result.status       = out_status;
  assign result.top_value    = out_top;
  assign result.depth        = out_depth;
  assign result.program_done = out_done;

  // ---------------------------------------------------------------------------
  // Cell chain: cell 0 is the top of stack and takes the pushed value or the
  // arithmetic result; every other cell takes its neighbour above on a push
  // and its neighbour below on a pop. The bottom cell refills with zero.
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] up_val;
    logic [DATA_W-1:0] down_val;

    if (i == 0) begin : g_top
      assign up_val = top_in;
    end else begin : g_inner
      assign up_val = cell_val[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign down_val = '0;
    end else begin : g_upper
      assign down_val = cell_val[i+1];
    end

    isa_cell u_cell (
      .clk       (clk),
      .cmd       ((i == 0) ? cmd_top : cmd_rest),
      .from_up   (up_val),
      .from_down (down_val),
      .value     (cell_val[i])
    );
  end

  isa_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );
endmodule
`default_nettype wire
